[rtl/tan_pkg.sv]
// ---------------------------------------------------------------------------
// tan_pkg
// Shared widths, types and helpers for the Tanimoto similarity block.
// ---------------------------------------------------------------------------
package tan_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned CountW      = 4;
  localparam int unsigned TotalW      = 12;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned ScoreW      = FracBits + 1;
  localparam int unsigned StepW       = $clog2(FracBits);
  localparam int unsigned MaxBytes    = 256;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  // Totals of one finished fingerprint, handed from front to back
  typedef struct packed {
    logic [TotalW-1:0] and_total;
    logic [TotalW-1:0] or_total;
  } tan_totals_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_WAIT
  } tan_back_state_e;

  function automatic logic [CountW-1:0] count_bits8(input logic [ByteW-1:0] v);
    logic [CountW-1:0] n;
    n = '0;
    for (int i = 0; i < ByteW; i++) begin
      n = n + CountW'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [TotalW-1:0] add_sat(input logic [TotalW-1:0] total,
                                                input logic [CountW-1:0] inc);
    logic [TotalW:0] s;
    s = {1'b0, total} + (TotalW+1)'(inc);
    return s[TotalW] ? TotalMax : s[TotalW-1:0];
  endfunction

endpackage

[rtl/tan_front.sv]
// ---------------------------------------------------------------------------
// tan_front
// Accumulates AND and OR bit counts per byte pair; pushes totals on last.
// ---------------------------------------------------------------------------
module tan_front import tan_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ByteW-1:0]  byte_a_i,
  input  logic [ByteW-1:0]  byte_b_i,
  input  logic              last_byte_i,
  input  logic              full_i,
  output logic              push_o,
  output tan_totals_t       push_data_o
);

  logic [TotalW-1:0] and_q, and_d;
  logic [TotalW-1:0] or_q, or_d;
  logic [TotalW-1:0] and_sum, or_sum;
  logic              accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;

  assign and_sum = add_sat(and_q, count_bits8(byte_a_i & byte_b_i));
  assign or_sum  = add_sat(or_q, count_bits8(byte_a_i | byte_b_i));

  always_comb begin
    and_d = and_q;
    or_d  = or_q;
    if (accept) begin
      // clear after the last beat, otherwise keep the running sums
      and_d = last_byte_i ? '0 : and_sum;
      or_d  = last_byte_i ? '0 : or_sum;
    end
  end

  assign push_o                = accept & last_byte_i;
  assign push_data_o.and_total = and_sum;
  assign push_data_o.or_total  = or_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      and_q <= '0;
      or_q  <= '0;
    end else begin
      and_q <= and_d;
      or_q  <= or_d;
    end
  end

endmodule

[rtl/tan_queue.sv]
// ---------------------------------------------------------------------------
// tan_queue
// Small register queue of finished totals between front and back.
// ---------------------------------------------------------------------------
module tan_queue import tan_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  tan_totals_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output tan_totals_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tan_totals_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/tan_back.sv]
// ---------------------------------------------------------------------------
// tan_back
// Restoring divider for the Q1.16 score, one quotient bit per cycle, with
// an output register facing the result channel.
// ---------------------------------------------------------------------------
module tan_back import tan_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  tan_totals_t       q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ScoreW-1:0] similarity_o,
  output logic [TotalW-1:0] common_bits_o,
  output logic [TotalW-1:0] union_bits_o,
  output logic              empty_union_o
);

  localparam logic [StepW-1:0] LastStep = StepW'(FracBits - 1);

  tan_back_state_e   state_q, state_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [TotalW-1:0] rem_q, rem_d;
  logic [ScoreW-1:0] quo_q, quo_d;
  logic [TotalW-1:0] and_q, and_d;
  logic [TotalW-1:0] or_q, or_d;
  logic              empty_q, empty_d;

  logic              out_valid_q, out_valid_d;
  logic [ScoreW-1:0] sim_q, sim_d;
  logic [TotalW-1:0] com_q, com_d;
  logic [TotalW-1:0] uni_q, uni_d;
  logic              emp_q, emp_d;

  logic              out_free;
  logic              load_out;
  logic [TotalW:0]   rem_sh;
  logic [TotalW:0]   rem_diff;
  logic              q_bit;
  logic              first_ge;

  assign out_free = ~out_valid_q | ~out_stall_i;

  // one shift-and-subtract step
  assign rem_sh   = {rem_q, 1'b0};
  assign rem_diff = rem_sh - {1'b0, or_q};
  assign q_bit    = ~rem_diff[TotalW];

  assign first_ge = (q_data_i.and_total >= q_data_i.or_total);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    and_d    = and_q;
    or_d     = or_q;
    empty_d  = empty_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          and_d   = q_data_i.and_total;
          or_d    = q_data_i.or_total;
          empty_d = (q_data_i.or_total == '0);
          step_d  = '0;
          // integer bit of the quotient decided up front
          quo_d   = {{(ScoreW-1){1'b0}}, first_ge};
          rem_d   = first_ge ? q_data_i.and_total - q_data_i.or_total
                             : q_data_i.and_total;
          state_d = (q_data_i.or_total == '0) ? BK_WAIT : BK_RUN;
        end
      end
      BK_RUN: begin
        quo_d  = {quo_q[ScoreW-2:0], q_bit};
        rem_d  = q_bit ? rem_diff[TotalW-1:0] : rem_sh[TotalW-1:0];
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = BK_WAIT;
        end
      end
      BK_WAIT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    sim_d       = sim_q;
    com_d       = com_q;
    uni_d       = uni_q;
    emp_d       = emp_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      sim_d       = empty_q ? '0 : quo_q;
      com_d       = and_q;
      uni_d       = or_q;
      emp_d       = empty_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    and_q   <= and_d;
    or_q    <= or_d;
    empty_q <= empty_d;
    sim_q   <= sim_d;
    com_q   <= com_d;
    uni_q   <= uni_d;
    emp_q   <= emp_d;
  end

  assign out_valid_o   = out_valid_q;
  assign similarity_o  = sim_q;
  assign common_bits_o = com_q;
  assign union_bits_o  = uni_q;
  assign empty_union_o = emp_q;

endmodule

[rtl/bit_vector_tanimoto_similarity.sv]
// ---------------------------------------------------------------------------
// bit_vector_tanimoto_similarity
// Streams byte pairs of two fingerprints and reports their Tanimoto score
// (common bits over union bits, unsigned Q1.16) with both bit totals.
// ---------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  input    | in_valid_i / in_stall_o| byte_a_i, byte_b_i, last_byte_i
//  result   | out_valid_o/out_stall_i| similarity_o, common_bits_o,
//           |                        | union_bits_o, empty_union_o
//
//  The front end takes one byte-pair beat per cycle while the queue has
//  room. A beat marked last pushes the totals into a short queue; the back
//  end divides them (pop, 16 restoring steps, load of the output register)
//  while the front end goes on with the next fingerprint.
//  Reset clears totals, queue pointers, divider state and output valid.
//  in_stall_o rises only while the queue is full; a stalled result holds
//  in the output register while the divider carries on with the next one.
//
module bit_vector_tanimoto_similarity import tan_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ByteW-1:0]  byte_a_i,
  input  logic [ByteW-1:0]  byte_b_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ScoreW-1:0] similarity_o,
  output logic [TotalW-1:0] common_bits_o,
  output logic [TotalW-1:0] union_bits_o,
  output logic              empty_union_o
);

  // Front to queue: totals of a finished fingerprint
  logic        push;
  tan_totals_t push_data;
  logic        q_full;

  // Queue to back
  logic        q_valid;
  tan_totals_t q_data;
  logic        pop;

  // Accumulate the AND and OR bit counts; stall only on a full queue
  tan_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .byte_a_i    (byte_a_i),
    .byte_b_i    (byte_b_i),
    .last_byte_i (last_byte_i),
    .full_i      (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decouple accumulation from the slow divide
  tan_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  // Divide and present the result beat
  tan_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .similarity_o  (similarity_o),
    .common_bits_o (common_bits_o),
    .union_bits_o  (union_bits_o),
    .empty_union_o (empty_union_o)
  );

endmodule
